>>> hw/rtl/n2a_pkg.sv
// Shared types, constants and helpers for the number-to-ASCII formatter.
package n2a_pkg;

  // Decimal conversion keeps this many digits of a 32-bit value
  localparam int DEC_DIGITS = 10;

  // Item character counter (up to ten characters per item)
  localparam int CNT_W = 4;

  // Character count for the "0x" plus eight hex digit form
  localparam logic [CNT_W-1:0] HEX_WORD_LEN = CNT_W'(10);
  localparam logic [CNT_W-1:0] HEX_BYTE_LEN = CNT_W'(2);
  localparam logic [CNT_W-1:0] RAW_LEN      = CNT_W'(1);
  localparam logic [CNT_W-1:0] DEC_MAX      = CNT_W'(DEC_DIGITS);

  // Reciprocal of ten: floor(x / 10) == (x * RECIP10) >> RECIP10_SHIFT for 32-bit x
  localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
  localparam int          RECIP10_SHIFT = 35;

  localparam logic [7:0] CHAR_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CHAR_X    = 8'h78;  // 'x'
  localparam logic [7:0] HEX_ALPHA = 8'h37;  // 'A' - 10

  typedef enum logic [1:0] {
    OP_RAW      = 2'd0,
    OP_DEC      = 2'd1,
    OP_HEX_BYTE = 2'd2,
    OP_HEX_WORD = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             load;       // capture the accepted item
    logic             conv_step;  // peel off one decimal digit
    logic             emit;       // write one character to the output register
    logic             last;       // final character of the item
    logic [CNT_W-1:0] idx;        // character position within the item
  } n2a_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;  // output register can take a character this cycle
  } n2a_sts_t;

  // Uppercase hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ext;
    ext = {4'h0, nib};
    return (nib <= 4'd9) ? CHAR_ZERO + ext : HEX_ALPHA + ext;
  endfunction

endpackage

>>> hw/rtl/n2a_ctrl.sv
// Sequencer for the formatter: accept, decimal conversion steps, character emission.
module n2a_ctrl
  import n2a_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] opcode,
  input  logic [3:0] digit_count,
  input  n2a_sts_t   sts,
  output n2a_cmd_t   cmd
);

  state_t           state, state_next;
  logic [CNT_W-1:0] n, n_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] n_in;

  // Number of characters the incoming item produces
  always_comb begin
    case (opcode_t'(opcode))
      OP_RAW:      n_in = RAW_LEN;
      OP_DEC:      n_in = (digit_count > DEC_MAX) ? DEC_MAX : digit_count;
      OP_HEX_BYTE: n_in = HEX_BYTE_LEN;
      OP_HEX_WORD: n_in = HEX_WORD_LEN;
      default:     n_in = RAW_LEN;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      n     <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      n     <= n_next;
      cnt   <= cnt_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    n_next        = n;
    cnt_next      = cnt;
    cmd           = '0;
    cmd.idx       = cnt;
    in_stall      = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          n_next   = n_in;
          cnt_next = '0;
          if (n_in == '0) begin
            state_next = ST_IDLE;
          end else if (opcode_t'(opcode) == OP_DEC) begin
            state_next = ST_CONV;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == n - 1'b1) begin
          cnt_next   = '0;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = (cnt == n - 1'b1);
          cnt_next = cnt + 1'b1;
          if (cmd.last) begin
            cnt_next   = '0;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/n2a_dpath.sv
// Datapath: item registers, divide-by-ten digit unit, character select, fill count, output register.
module n2a_dpath
  import n2a_pkg::*;
#(
  parameter int BUF_CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  opcode,
  input  logic [31:0] value,
  input  n2a_cmd_t    cmd,
  output n2a_sts_t    sts,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  character,
  output logic [5:0]  slot,
  output logic        stored,
  output logic        last
);

  localparam int FILL_W = $clog2(BUF_CAPACITY + 1);

  opcode_t                      opc;
  logic [31:0]                  work;
  logic [DEC_DIGITS-1:0][3:0]   digs;
  logic [FILL_W-1:0]            fill_count;

  logic [63:0] prod;
  logic [31:0] quot;
  logic [31:0] rem_full;
  logic [3:0]  rem;
  logic [2:0]  nib_sel;
  logic [7:0]  char_sel;
  logic        room;

  // Divide by ten through the reciprocal, remainder by shift-add
  always_comb begin
    prod     = 64'(work) * 64'(RECIP10);
    quot     = 32'(prod >> RECIP10_SHIFT);
    rem_full = work - ((quot << 3) + (quot << 1));
    rem      = rem_full[3:0];
  end

  // Character for the current position
  always_comb begin
    nib_sel = 3'(HEX_WORD_LEN - 1'b1 - cmd.idx);
    case (opc)
      OP_RAW:      char_sel = work[7:0];
      OP_DEC:      char_sel = CHAR_ZERO + {4'h0, digs[cmd.idx]};
      OP_HEX_BYTE: char_sel = (cmd.idx == '0) ? hex_char(work[7:4]) : hex_char(work[3:0]);
      OP_HEX_WORD: begin
        if (cmd.idx == '0) begin
          char_sel = CHAR_ZERO;
        end else if (cmd.idx == CNT_W'(1)) begin
          char_sel = CHAR_X;
        end else begin
          char_sel = hex_char(work[{nib_sel, 2'b00} +: 4]);
        end
      end
      default:     char_sel = work[7:0];
    endcase
  end

  assign room         = (fill_count < FILL_W'(BUF_CAPACITY));
  assign sts.out_free = !out_valid || !out_stall;

  // Item registers and digit shift line (most significant digit ends at index 0)
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opc  <= opcode_t'(opcode);
      work <= value;
    end else if (cmd.conv_step) begin
      work <= quot;
      digs <= {digs[DEC_DIGITS-2:0], rem};
    end
  end

  // Fill count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (room) begin
          fill_count <= fill_count + 1'b1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      character <= char_sel;
      slot      <= room ? 6'(fill_count) : 6'd0;
      stored    <= room;
      last      <= cmd.last;
    end
  end

endmodule

>>> hw/rtl/number_to_ascii_formatter.sv
// Top level of the number-to-ASCII formatter: controller plus datapath.
// An item is taken from the input and then yields its characters one per cycle
// through a single output register, each tagged with its buffer slot, a stored
// flag (cleared once BUF_CAPACITY characters are in the buffer) and a last flag.
// A decimal item's digits are first produced one per cycle by a divide-by-ten
// unit (reciprocal multiply) and then sent most significant first. A decimal
// item with zero digits yields nothing. Output stall holds emission in place; a
// new item is taken as soon as the previous item's last character is in the
// output register.
module number_to_ascii_formatter
  import n2a_pkg::*;
#(
  parameter int BUF_CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [31:0] value,
  input  logic [3:0]  digit_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  character,
  output logic [5:0]  slot,
  output logic        stored,
  output logic        last
);

  n2a_cmd_t cmd;
  n2a_sts_t sts;

  // Sequencer
  n2a_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .digit_count (digit_count),
    .sts         (sts),
    .cmd         (cmd)
  );

  // Datapath
  n2a_dpath #(
    .BUF_CAPACITY (BUF_CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .opcode    (opcode),
    .value     (value),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .slot      (slot),
    .stored    (stored),
    .last      (last)
  );

endmodule
